// ===== rtl/core/stack_with_middle_ops_top_macros.svh =====
// ----------------------------------------------------------------------------
// stack_with_middle_ops_top_macros.svh
// Assertion macros shared by the stack checker.
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_OPS_TOP_MACROS_SVH
`define STACK_WITH_MIDDLE_OPS_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define SWMO_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stack check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define SWMO_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stack check failed");

`endif

// ===== rtl/core/swmo_pkg.sv =====
// ----------------------------------------------------------------------------
// swmo_pkg
// Types and constants of the stack with middle-element access.
// ----------------------------------------------------------------------------
`default_nettype none

package swmo_pkg;

	localparam int DATA_W      = 32;
	localparam int DEPTH_NOW_W = 7;
	localparam int DEPTH_DEF   = 64;
	// wide enough for any position or count up to 8191
	localparam int POS_W_MAX   = 13;

	typedef enum logic [1:0] {
		CMD_PUSH     = 2'd0,
		CMD_POP      = 2'd1,
		CMD_READ_MID = 2'd2,
		CMD_DEL_MID  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W_MAX-1:0]     pos_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic wr_en;    // push: the cell at wr_pos loads the pushed word
		logic sh_en;    // delete middle: cells in [sh_lo, sh_hi) take their upper neighbor
		pos_t wr_pos;
		pos_t sh_lo;
		pos_t sh_hi;
		pos_t rd_pos;   // cell that drives the read bus
	} cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/swmo_if.sv =====
// ----------------------------------------------------------------------------
// swmo_if
// Valid/ready channels of the stack: command words in, result words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface swmo_req_if;
	import swmo_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	data_t value_in;

	modport source (output valid, output cmd, output value_in, input ready);
	modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

interface swmo_rsp_if;
	import swmo_pkg::*;

	logic                   valid;
	logic                   ready;
	data_t                  value_out;
	status_t                status;
	logic [DEPTH_NOW_W-1:0] depth_now;

	modport source (output valid, output value_out, output status, output depth_now,
		input ready);
	modport sink   (input valid, input value_out, input status, input depth_now,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/swmo_cell.sv =====
// ----------------------------------------------------------------------------
// swmo_cell
// One stack slot: loads a pushed word, shifts down from its upper neighbor,
// and drives the shared read bus when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module swmo_cell #(
	parameter int INDEX = 0
) (
	input  wire                       clk,
	input  wire swmo_pkg::cell_ctl_t  ctl,
	input  wire swmo_pkg::data_t      wr_data,
	input  wire swmo_pkg::data_t      upper_data,
	output swmo_pkg::data_t           data,
	output swmo_pkg::data_t           rd_data
);
	import swmo_pkg::*;

	localparam pos_t IDX = POS_W_MAX'(INDEX);

	data_t data_q;
	logic  wr_hit;
	logic  sh_hit;

	assign wr_hit = ctl.wr_en && (ctl.wr_pos == IDX);
	assign sh_hit = ctl.sh_en && (IDX >= ctl.sh_lo) && (IDX < ctl.sh_hi);

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			data_q <= wr_data;
		end else if (sh_hit) begin
			data_q <= upper_data;
		end
	end

	assign data    = data_q;
	assign rd_data = (ctl.rd_pos == IDX) ? data_q : '0;

endmodule

`default_nettype wire

// ===== rtl/core/stack_with_middle_ops_top.sv =====
// ----------------------------------------------------------------------------
// stack_with_middle_ops_top
// Bounded stack of signed 32-bit words with read and delete of the middle.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command word (cmd, value_in): push, pop, read middle or
//   delete middle. rsp returns exactly one result word per command:
//   value_out, status (ok / empty / full) and depth_now after the command.
//   The middle is slot count/2 from the bottom. Delete middle moves every
//   slot above it down by one in the same cycle, across the cell chain.
// Timing:
//   The result is registered at the edge that accepts the word. A new
//   command is taken every cycle while rsp is drained; the one-hot read
//   bus over the cells and the shift enables decoded in every cell set
//   the cycle time.
// Reset:
//   arst_n clears the element count and the result valid; slot contents
//   stay undefined until pushed.
// Stall:
//   While a result waits on rsp.ready, req.ready drops and state holds.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_middle_ops_top #(
	parameter int DEPTH = swmo_pkg::DEPTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	swmo_req_if.sink   req,
	swmo_rsp_if.source rsp
);
	import swmo_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CNT_W-1:0] mid_pos;
	logic [CNT_W-1:0] top_pos;
	logic             rsp_valid_q;
	data_t            value_out_q;
	status_t          status_q;
	logic [DEPTH_NOW_W-1:0] depth_now_q;

	logic      accept;
	logic      empty;
	logic      full;
	status_t   status_nxt;
	data_t     value_nxt;
	data_t     rd_bus;
	cell_ctl_t ctl;

	data_t cell_data [DEPTH];
	data_t cell_rd   [DEPTH];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign mid_pos = count_q >> 1;
	assign top_pos = count_q - CNT_W'(1);

	always_comb begin
		status_nxt = ST_OK;
		count_nxt  = count_q;
		ctl        = '0;
		ctl.wr_pos = POS_W_MAX'(count_q);
		ctl.sh_lo  = POS_W_MAX'(mid_pos);
		ctl.sh_hi  = POS_W_MAX'(top_pos);
		ctl.rd_pos = POS_W_MAX'(mid_pos);
		unique case (req.cmd)
			CMD_PUSH: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt  = count_q + CNT_W'(1);
					ctl.wr_en  = accept;
				end
			end
			CMD_POP: begin
				ctl.rd_pos = POS_W_MAX'(top_pos);
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = top_pos;
				end
			end
			CMD_READ_MID: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end
			end
			CMD_DEL_MID: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					count_nxt = top_pos;
					ctl.sh_en = accept;
				end
			end
			default: begin
				status_nxt = ST_OK;
			end
		endcase
	end

	// read bus: only the addressed cell drives nonzero
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	assign value_nxt = ((status_nxt == ST_OK) && (req.cmd != CMD_PUSH)) ? rd_bus : '0;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		data_t upper;
		if (g == DEPTH - 1) begin : g_last
			assign upper = '0;
		end else begin : g_mid
			assign upper = cell_data[g+1];
		end
		swmo_cell #(
			.INDEX (g)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.wr_data    (req.value_in),
			.upper_data (upper),
			.data       (cell_data[g]),
			.rd_data    (cell_rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_out_q <= value_nxt;
			status_q    <= status_nxt;
			depth_now_q <= DEPTH_NOW_W'(count_nxt);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = value_out_q;
	assign rsp.status    = status_q;
	assign rsp.depth_now = depth_now_q;

endmodule

`default_nettype wire

// ===== rtl/core/swmo_chk.sv =====
// ----------------------------------------------------------------------------
// swmo_chk
// Port-level checks of the stack, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_with_middle_ops_top_macros.svh"

module swmo_chk (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           req_valid,
	input wire                           req_ready,
	input wire                           rsp_valid,
	input wire                           rsp_ready,
	input wire swmo_pkg::data_t          rsp_value_out,
	input wire swmo_pkg::status_t        rsp_status
);
	import swmo_pkg::*;

	// a waiting result holds until taken
	`SWMO_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	// with the result slot free the block always takes a command
	`SWMO_ASSERT_IMP(a_req_ready_free, !rsp_valid, req_ready)
	// every accepted command produces a result in the next cycle
	`SWMO_ASSERT_NXT(a_one_cycle, req_valid && req_ready, rsp_valid)
	// refused or empty commands carry a zero word
	`SWMO_ASSERT_IMP(a_zero_on_err, rsp_valid && (rsp_status != ST_OK), rsp_value_out == '0)

endmodule

bind stack_with_middle_ops_top swmo_chk u_swmo_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_out (rsp.value_out),
	.rsp_status    (rsp.status)
);

`default_nettype wire

// ===== sim/tb_stack_with_middle_ops_top.sv =====
// ----------------------------------------------------------------------------
// tb_stack_with_middle_ops_top
// Self-checking bench for the stack with read/delete of the middle element.
// A tracker keeps its own copy of the stack and predicts one result word
// per accepted command. Directed corner cases come first. Random phases then
// fill the stack to full, churn near the top, drain to empty and walk at low
// depth, with random idling on both channels in all but one low-depth phase.
// ----------------------------------------------------------------------------
module tb_stack_with_middle_ops_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swmo_pkg::*;

	localparam int STACK_DEPTH = DEPTH_DEF;
	localparam int STALL_LIMIT = 2000;
	localparam data_t WORD_MAX = 32'sh7FFF_FFFF;
	localparam data_t WORD_MIN = 32'sh8000_0000;

	typedef struct {
		data_t                  value;
		status_t                status;
		logic [DEPTH_NOW_W-1:0] depth;
	} stack_result_t;

	class middle_stack_tracker;
		data_t         cells[STACK_DEPTH];
		int unsigned   fill;
		stack_result_t pending[$];
		int            errors;
		int            results_seen;
		int            full_seen;
		int            empty_seen;
		int            peak;

		function void apply_command(cmd_t c, data_t v);
			stack_result_t r;
			int unsigned   mid;
			r.value  = '0;
			r.status = ST_OK;
			if (c == CMD_PUSH) begin
				if (fill >= STACK_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					cells[fill] = v;
					fill++;
				end
			end else if (fill == 0) begin
				r.status = ST_EMPTY;
			end else if (c == CMD_POP) begin
				fill--;
				r.value = cells[fill];
			end else begin
				// upper of the two central words on an even count
				mid = fill / 2;
				r.value = cells[mid];
				if (c == CMD_DEL_MID) begin
					for (int unsigned i = mid; i + 1 < fill; i++)
						cells[i] = cells[i + 1];
					fill--;
				end
			end
			r.depth = DEPTH_NOW_W'(fill);
			if (fill > peak)
				peak = fill;
			pending.push_back(r);
		endfunction

		function void check_result(data_t v, status_t s, logic [DEPTH_NOW_W-1:0] d);
			stack_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result word with nothing expected: value %0d status %0d depth %0d",
					$time, v, s, d);
				return;
			end
			e = pending.pop_front();
			if (e.status == ST_FULL)
				full_seen++;
			if (e.status == ST_EMPTY)
				empty_seen++;
			if (v !== e.value) begin
				errors++;
				$display("%0t: value_out mismatch: expected %0d, got %0d",
					$time, e.value, v);
			end
			if (s !== e.status) begin
				errors++;
				$display("%0t: status mismatch: expected %0d, got %0d",
					$time, e.status, s);
			end
			if (d !== e.depth) begin
				errors++;
				$display("%0t: depth_now mismatch: expected %0d, got %0d",
					$time, e.depth, d);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   idle_on;
	int   stall_cycles;
	int   cmd_count[4];

	middle_stack_tracker tracker;

	swmo_req_if req_ch ();
	swmo_rsp_if rsp_ch ();

	stack_with_middle_ops_top #(
		.DEPTH(STACK_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #2 clk = ~clk;

	// mostly short gaps, a few long ones; none while idling is off
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic data_t random_word();
		case ($urandom_range(15))
			0:       return WORD_MAX;
			1:       return WORD_MIN;
			2:       return '0;
			3:       return -1;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic cmd_t random_cmd(int push_pct);
		if ($urandom_range(99) < push_pct)
			return CMD_PUSH;
		case ($urandom_range(2))
			0:       return CMD_POP;
			1:       return CMD_READ_MID;
			default: return CMD_DEL_MID;
		endcase
	endfunction

	// returns right after the word is taken; valid stays high until the next call
	task automatic send_command(cmd_t c, data_t v);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.cmd      <= c;
		req_ch.value_in <= v;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic stop_sending();
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (tracker.pending.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(int n, int push_pct);
		repeat (n) send_command(random_cmd(push_pct), random_word());
	endtask

	// result side
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				tracker.check_result(rsp_ch.value_out, rsp_ch.status, rsp_ch.depth_now);
			if (req_ch.valid && req_ch.ready) begin
				tracker.apply_command(req_ch.cmd, req_ch.value_in);
				cmd_count[req_ch.cmd]++;
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		idle_on         = 1'b0;
		stall_cycles    = 0;
		req_ch.valid    = 1'b0;
		req_ch.cmd      = CMD_PUSH;
		req_ch.value_in = '0;
		rsp_ch.ready    = 1'b0;
		tracker         = new;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty stack on every non-push command
		send_command(CMD_POP, 32'sd7);
		send_command(CMD_READ_MID, -1);
		send_command(CMD_DEL_MID, WORD_MIN);
		// single word: middle is the bottom
		send_command(CMD_PUSH, WORD_MAX);
		send_command(CMD_DEL_MID, '0);
		send_command(CMD_PUSH, WORD_MAX);
		send_command(CMD_PUSH, WORD_MIN);
		send_command(CMD_PUSH, -1);
		send_command(CMD_PUSH, '0);
		// even and odd counts, deletes closing the gap
		send_command(CMD_READ_MID, '0);
		send_command(CMD_DEL_MID, '0);
		send_command(CMD_READ_MID, '0);
		send_command(CMD_DEL_MID, '0);
		send_command(CMD_READ_MID, '0);
		send_command(CMD_POP, '0);
		send_command(CMD_POP, '0);
		send_command(CMD_POP, '0);
		send_command(CMD_PUSH, 32'sh5555_5555);
		send_command(CMD_PUSH, 32'shAAAA_AAAA);
		send_command(CMD_DEL_MID, '0);
		send_command(CMD_DEL_MID, '0);

		idle_on = 1'b1;
		run_random(160, 85);    // climb to full, then push into it
		run_random(100, 50);    // churn near the top
		stop_sending();
		wait_drained();
		run_random(150, 20);    // drain to empty
		idle_on = 1'b0;
		run_random(80, 50);
		idle_on = 1'b1;
		run_random(80, 50);

		stop_sending();
		wait_drained();
		repeat (5) @(posedge clk);

		$display("Ran %0d push, %0d pop, %0d read-middle, %0d delete-middle words; %0d results",
			cmd_count[CMD_PUSH], cmd_count[CMD_POP], cmd_count[CMD_READ_MID],
			cmd_count[CMD_DEL_MID], tracker.results_seen);
		$display("Peak depth %0d of %0d, %0d full refusals, %0d empty replies",
			tracker.peak, STACK_DEPTH, tracker.full_seen, tracker.empty_seen);
		if (tracker.errors == 0 && tracker.pending.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
